>>> hw/rtl/skf_pkg.sv
// Package for the scalar Kalman filter: widths, register codes, reset values,
// sequencer state and control types. Depends on nothing.
package skf_pkg;

  localparam int SKF_CHANNELS = 4;
  localparam int CH_W         = 2;
  localparam int DATA_W       = 32;
  localparam int FRAC_W       = 16;
  localparam int GAIN_W       = 17;
  localparam int DEN_W        = 33;
  localparam int REM_W        = 34;
  localparam int DIFF_W       = 33;
  localparam int MUL_A_W      = 18;
  localparam int MUL_B_W      = 34;
  localparam int MUL_P_W      = MUL_A_W + MUL_B_W;
  localparam int DIV_STEPS    = 17;
  localparam int DIV_CNT_W    = 5;
  localparam int CFG_IDX_W    = 8;

  localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MEASUREMENT_NOISE = 8'd1;

  localparam logic [DATA_W-1:0] PROCESS_NOISE_RESET     = 32'd3277;
  localparam logic [DATA_W-1:0] MEASUREMENT_NOISE_RESET = 32'd327680;

  localparam logic [GAIN_W-1:0] GAIN_ONE = 17'd65536;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PRED,
    S_DIV_GO,
    S_DIV_WAIT,
    S_MUL_X,
    S_MUL_P,
    S_WB,
    S_DONE
  } skf_state_t;

  typedef struct packed {
    logic in_valid;
    logic slot_ok;
    logic div_done;
    logic out_free;
  } skf_stat_t;

  typedef struct packed {
    logic in_ready;
    logic calc_pred;
    logic div_start;
    logic cap_gain;
    logic mul_sel_p;
    logic upd_est;
    logic write_back;
    logic load_out;
  } skf_ctrl_t;

endpackage

>>> hw/rtl/skf_if.sv
// Handshake interfaces for the scalar Kalman filter's input, result and
// configuration channels. Depends on skf_pkg.
interface skf_in_if import skf_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CH_W-1:0]          channel;
  logic signed [DATA_W-1:0] measurement;

  modport source (output valid, output channel, output measurement, input ready);
  modport sink   (input valid, input channel, input measurement, output ready);
endinterface

interface skf_out_if import skf_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] estimate;
  logic [CH_W-1:0]          out_channel;

  modport source (output valid, output estimate, output out_channel, input ready);
  modport sink   (input valid, input estimate, input out_channel, output ready);
endinterface

interface skf_cfg_if import skf_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DATA_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/scalar_kalman_filter.sv
// Scalar Kalman filter top level: configuration registers, per-channel state
// and the datapath around the divider and multiplier. Depends on skf_pkg,
// the interfaces in skf_if, skf_div, skf_mul and skf_seq.
//
// Usage: a measurement word on in_if carries a channel number and a signed
// Q16.16 value. The block updates that channel's estimate and covariance as a
// one-dimensional Kalman filter and returns one word on out_if with the new
// estimate and the channel. Channels at or above CHANNELS leave the state
// untouched and return an estimate of zero.
// The cfg_if channel writes the process noise (index 0) and the measurement
// noise (index 1); other indexes are ignored. It is ready whenever reset is
// released, and writes are meant to happen while no measurement is in flight.
// A word passes through prediction, division, the two multiplies, write-back
// and the output register, and a new word is taken only once the result has
// been loaded there; the 17 steps of the bit-serial gain divider take most of
// that time, and a word for a channel outside the slots skips to the hand-off.
// Reset clears every estimate and covariance to zero and loads the default
// noise values; while it is held, neither in_if nor cfg_if is ready. The
// result sits in an output register; if the receiver stalls, the block still
// takes and processes the next word and then waits with its result until the
// output register is free.
module scalar_kalman_filter import skf_pkg::*; #(
  parameter int CHANNELS = SKF_CHANNELS
) (
  input  logic       clk,
  input  logic       rst_n,
  skf_in_if.sink     in_if,
  skf_out_if.source  out_if,
  skf_cfg_if.sink    cfg_if
);

  // Only four channel numbers can be addressed, so at most four slots exist.
  localparam int SLOTS = (CHANNELS < 4) ? CHANNELS : 4;
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  skf_stat_t stat;
  skf_ctrl_t ctrl;

  logic [DATA_W-1:0]        q_r;
  logic [DATA_W-1:0]        r_r;
  logic signed [DATA_W-1:0] est_r [SLOTS];
  logic [DATA_W-1:0]        cov_r [SLOTS];

  logic [CH_W-1:0]          ch_r;
  logic signed [DATA_W-1:0] z_r;
  logic signed [DATA_W-1:0] x_r;
  logic [DATA_W-1:0]        pred_r;
  logic [GAIN_W-1:0]        gain_r;
  logic signed [DATA_W-1:0] est_res_r;
  logic signed [DATA_W-1:0] est_res_nxt;

  logic                     out_valid_r;
  logic signed [DATA_W-1:0] out_est_r;
  logic [CH_W-1:0]          out_ch_r;

  logic [IDX_W-1:0]         idx;
  logic                     in_fire;
  logic [DATA_W:0]          pred_sum;
  logic [DATA_W-1:0]        pred_nxt;
  logic [DEN_W-1:0]         den;
  logic signed [DIFF_W-1:0] diff;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] product;
  logic                     div_done;
  logic [GAIN_W-1:0]        quotient;
  logic [GAIN_W-1:0]        gain_rest;

  assign idx     = ch_r[IDX_W-1:0];
  assign in_fire = in_if.valid && in_if.ready;

  // Configuration registers.
  assign cfg_if.ready = rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= PROCESS_NOISE_RESET;
      r_r <= MEASUREMENT_NOISE_RESET;
    end else if (cfg_if.valid) begin
      if (cfg_if.index == REG_PROCESS_NOISE) begin
        q_r <= cfg_if.data;
      end else if (cfg_if.index == REG_MEASUREMENT_NOISE) begin
        r_r <= cfg_if.data;
      end
    end
  end

  // Prediction saturates at the largest covariance instead of wrapping.
  always_comb begin
    pred_sum = {1'b0, cov_r[idx]} + {1'b0, q_r};
    pred_nxt = pred_sum[DATA_W] ? '1 : pred_sum[DATA_W-1:0];
  end

  assign den = {1'b0, pred_r} + {1'b0, r_r};

  skf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (ctrl.div_start),
    .pred     (pred_r),
    .den      (den),
    .done     (div_done),
    .quotient (quotient)
  );

  // The multiplier first forms gain * (z - x), then (1 - gain) * pred.
  assign diff      = {z_r[DATA_W-1], z_r} - {x_r[DATA_W-1], x_r};
  assign gain_rest = GAIN_ONE - gain_r;

  always_comb begin
    if (ctrl.mul_sel_p) begin
      mul_a = {1'b0, gain_rest};
      mul_b = {2'b00, pred_r};
    end else begin
      mul_a = {1'b0, gain_r};
      mul_b = {diff[DIFF_W-1], diff};
    end
  end

  skf_mul u_mul (
    .clk     (clk),
    .a       (mul_a),
    .b       (mul_b),
    .product (product)
  );

  // The new estimate lies between x and z, so the low 32 bits of the floored
  // correction added to x give it exactly.
  assign est_res_nxt = x_r + product[FRAC_W+DATA_W-1:FRAC_W];

  // Item registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      ch_r      <= in_if.channel;
      z_r       <= in_if.measurement;
      est_res_r <= '0;
    end
    if (ctrl.calc_pred) begin
      x_r    <= est_r[idx];
      pred_r <= pred_nxt;
    end
    if (ctrl.cap_gain) begin
      gain_r <= quotient;
    end
    if (ctrl.upd_est) begin
      est_res_r <= est_res_nxt;
    end
  end

  // Channel state. The covariance term never exceeds pred, so it needs no
  // saturation.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        est_r[i] <= '0;
        cov_r[i] <= '0;
      end
    end else if (ctrl.write_back) begin
      est_r[idx] <= est_res_r;
      cov_r[idx] <= product[FRAC_W+DATA_W-1:FRAC_W];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_out) begin
      out_est_r <= est_res_r;
      out_ch_r  <= ch_r;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.estimate    = out_est_r;
  assign out_if.out_channel = out_ch_r;
  assign in_if.ready        = ctrl.in_ready && rst_n;

  assign stat.in_valid = in_if.valid;
  assign stat.slot_ok  = ({1'b0, ch_r} < 3'(SLOTS));
  assign stat.div_done = div_done;
  assign stat.out_free = !out_valid_r || out_if.ready;

  skf_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

endmodule

>>> hw/rtl/skf_div.sv
// Restoring divider that forms the 17-bit gain pred * 2^16 / den, one
// quotient bit per cycle. Depends on skf_pkg.
module skf_div import skf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DATA_W-1:0] pred,
  input  logic [DEN_W-1:0]  den,
  output logic              done,
  output logic [GAIN_W-1:0] quotient
);

  logic [REM_W-1:0]     rem_r, rem_nxt;
  logic [DEN_W-1:0]     den_r;
  logic [GAIN_W-1:0]    quo_r, quo_nxt;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic                 zero_r;
  logic [REM_W-1:0]     trial;
  logic                 fits;

  // Each step compares the partial remainder against the divisor, then
  // shifts it up for the next quotient bit.
  always_comb begin
    trial   = rem_r - {1'b0, den_r};
    fits    = rem_r >= {1'b0, den_r};
    quo_nxt = {quo_r[GAIN_W-2:0], fits};
    rem_nxt = fits ? {trial[REM_W-2:0], 1'b0} : {rem_r[REM_W-2:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(DIV_STEPS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= {2'b00, pred};
      den_r  <= den;
      quo_r  <= '0;
      zero_r <= (den == '0);
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  // A zero divisor gives a gain of zero.
  assign quotient = zero_r ? '0 : quo_r;
  assign done     = done_r;

endmodule

>>> hw/rtl/skf_mul.sv
// Shared signed multiplier with a registered product, used for both the
// estimate and the covariance update. Depends on skf_pkg.
module skf_mul import skf_pkg::*; (
  input  logic                      clk,
  input  logic signed [MUL_A_W-1:0] a,
  input  logic signed [MUL_B_W-1:0] b,
  output logic signed [MUL_P_W-1:0] product
);

  logic signed [MUL_P_W-1:0] product_r;

  always_ff @(posedge clk) begin
    product_r <= a * b;
  end

  assign product = product_r;

endmodule

>>> hw/rtl/skf_seq.sv
// Sequencer that steps one measurement through prediction, division,
// the two multiplies, write-back and result hand-off. Depends on skf_pkg.
module skf_seq import skf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  skf_stat_t stat,
  output skf_ctrl_t ctrl
);

  skf_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (stat.in_valid) state_nxt = S_PRED;
      end
      S_PRED: begin
        state_nxt = stat.slot_ok ? S_DIV_GO : S_DONE;
      end
      S_DIV_GO: state_nxt = S_DIV_WAIT;
      S_DIV_WAIT: begin
        if (stat.div_done) state_nxt = S_MUL_X;
      end
      S_MUL_X: state_nxt = S_MUL_P;
      S_MUL_P: state_nxt = S_WB;
      S_WB:    state_nxt = S_DONE;
      S_DONE: begin
        if (stat.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    case (state_r)
      S_IDLE:     ctrl.in_ready   = 1'b1;
      S_PRED:     ctrl.calc_pred  = 1'b1;
      S_DIV_GO:   ctrl.div_start  = 1'b1;
      S_DIV_WAIT: ctrl.cap_gain   = stat.div_done;
      S_MUL_X:    ctrl.mul_sel_p  = 1'b0;
      S_MUL_P: begin
        ctrl.mul_sel_p = 1'b1;
        ctrl.upd_est   = 1'b1;
      end
      S_WB:       ctrl.write_back = 1'b1;
      S_DONE:     ctrl.load_out   = stat.out_free;
      default:    ctrl = '0;
    endcase
  end

endmodule

>>> tb/tb.sv
// Self-checking testbench for scalar_kalman_filter: a scoreboard class that
// predicts each filtered estimate, plus tasks that drive words and registers.
// Depends on skf_pkg, the skf_if interfaces and the scalar_kalman_filter RTL.
`timescale 1ns / 100ps

module tb;
  import skf_pkg::*;

  localparam logic signed [DATA_W-1:0] Z_MAX     = 32'sh7FFFFFFF;
  localparam logic signed [DATA_W-1:0] Z_MIN     = 32'sh80000000;
  localparam logic [DATA_W-1:0]        NOISE_MAX = 32'hFFFFFFFF;
  localparam int RAND_PHASES    = 8;
  localparam int WORDS_PER_PHASE = 244;
  localparam int MAX_GAP        = 40;
  // Longer than one word takes through the block, so a stray late word is caught.
  localparam int TAIL_CYCLES    = 40;

  // Idling profiles that the random phases rotate through.
  typedef enum int {
    PACE_FULL,
    PACE_SENDER_IDLE,
    PACE_RECEIVER_STALL,
    PACE_BOTH
  } pace_t;

  // One expected result word.
  typedef struct {
    logic signed [DATA_W-1:0] estimate;
    logic [CH_W-1:0]          channel;
  } filtered_t;

  // Scoreboard: keeps its own copy of the noise registers and of every slot's
  // estimate and covariance, and queues the estimate each accepted word should
  // produce, in order.
  class kalman_scoreboard;
    logic [DATA_W-1:0]        q_noise;
    logic [DATA_W-1:0]        r_noise;
    logic signed [DATA_W-1:0] est_mem [SKF_CHANNELS];
    logic [DATA_W-1:0]        cov_mem [SKF_CHANNELS];
    filtered_t                filtered_q [$];
    int                       errors;
    int                       checked;

    function new();
      q_noise = PROCESS_NOISE_RESET;
      r_noise = MEASUREMENT_NOISE_RESET;
      foreach (est_mem[i]) begin
        est_mem[i] = '0;
        cov_mem[i] = '0;
      end
      errors  = 0;
      checked = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] value);
      case (idx)
        REG_PROCESS_NOISE:     q_noise = value;
        REG_MEASUREMENT_NOISE: r_noise = value;
        default: ;
      endcase
    endfunction

    function int outstanding();
      return filtered_q.size();
    endfunction

    // Runs one filter update on the slot and queues the new estimate.
    function void note_measurement(logic [CH_W-1:0] ch, logic signed [DATA_W-1:0] z);
      logic [DATA_W:0]          pred_sum;
      logic [DATA_W-1:0]        pred;
      logic [DATA_W:0]          den;
      logic [63:0]              quot;
      logic [GAIN_W-1:0]        gain;
      longint                   diff;
      longint                   step;
      logic [63:0]              cov_next;
      logic signed [DATA_W-1:0] x;
      filtered_t                item;

      item.channel = ch;
      if (int'(ch) >= SKF_CHANNELS) begin
        // A slot that does not exist returns zero and touches nothing.
        item.estimate = '0;
        filtered_q.push_back(item);
        return;
      end
      x = est_mem[ch];

      // The prediction saturates instead of wrapping.
      pred_sum = {1'b0, cov_mem[ch]} + {1'b0, q_noise};
      pred = pred_sum[DATA_W] ? NOISE_MAX : pred_sum[DATA_W-1:0];

      // Gain in Q1.16; a zero divisor forces it to zero.
      den = {1'b0, pred} + {1'b0, r_noise};
      if (den == '0) begin
        gain = '0;
      end else begin
        quot = {16'b0, pred, 16'b0} / {31'b0, den};
        gain = quot[GAIN_W-1:0];
      end

      // The correction rounds toward minus infinity.
      diff = longint'(z) - longint'(x);
      step = (longint'(gain) * diff) >>> FRAC_W;
      x = x + DATA_W'(step);

      cov_next = ((64'd65536 - 64'(gain)) * 64'(pred)) >> FRAC_W;
      est_mem[ch] = x;
      cov_mem[ch] = (cov_next > 64'(NOISE_MAX)) ? NOISE_MAX : cov_next[DATA_W-1:0];

      item.estimate = x;
      filtered_q.push_back(item);
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH at %0t, result %0d: %s", $realtime, checked, msg);
      errors++;
    endtask

    // Compares one result word with the oldest expectation.
    task check_result(logic signed [DATA_W-1:0] est, logic [CH_W-1:0] ch);
      filtered_t want;
      checked++;
      if (filtered_q.size() == 0) begin
        report_mismatch($sformatf("unexpected word, estimate %h channel %0d", est, ch));
        return;
      end
      want = filtered_q.pop_front();
      if (est !== want.estimate)
        report_mismatch($sformatf("estimate %h, expected %h (channel %0d)",
                                  est, want.estimate, want.channel));
      if (ch !== want.channel)
        report_mismatch($sformatf("channel %0d, expected %0d", ch, want.channel));
    endtask
  endclass

  logic clk;
  logic rst_n;

  skf_in_if  in_if ();
  skf_out_if out_if ();
  skf_cfg_if cfg_if ();

  scalar_kalman_filter dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  kalman_scoreboard sb = new();

  // Chance, in percent, that the sender idles or the receiver stalls on a cycle.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // A slowly drifting level per channel, so that many measurements look like
  // a real sensor with noise around it.
  logic signed [DATA_W-1:0] level [SKF_CHANNELS];

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Receiver: checks every word taken, then picks next cycle's ready.
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_if.valid && out_if.ready)
        sb.check_result(out_if.estimate, out_if.out_channel);
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic set_pace(pace_t pace);
    case (pace)
      PACE_FULL: begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      PACE_SENDER_IDLE: begin
        send_idle_pct = 77;
        recv_stall_pct = 0;
      end
      PACE_RECEIVER_STALL: begin
        send_idle_pct = 0;
        recv_stall_pct = 77;
      end
      default: begin
        send_idle_pct = 16;
        recv_stall_pct = 16;
      end
    endcase
  endtask

  // Offers one measurement word and waits until it is taken. Valid stays high
  // when the next word follows right away, so it is only lowered for a gap.
  task automatic send_measurement(logic [CH_W-1:0] ch, logic signed [DATA_W-1:0] z);
    int gap;
    in_if.valid       <= 1'b1;
    in_if.channel     <= ch;
    in_if.measurement <= z;
    do @(posedge clk); while (!in_if.ready);
    sb.note_measurement(ch, z);
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct)
      gap++;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stops sending and waits until every expected estimate has come back.
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (sb.outstanding() != 0)
      @(posedge clk);
  endtask

  // One register write; valid is left high so back-to-back writes need no
  // second assignment in the same step.
  task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk); while (!cfg_if.ready);
    sb.write_reg(idx, value);
  endtask

  // Loads both noise registers, with a write to an unused index in between
  // that the block must ignore. Only called while the block is idle.
  task automatic program_noise(logic [DATA_W-1:0] q, logic [DATA_W-1:0] r);
    put_reg(REG_PROCESS_NOISE, q);
    put_reg(CFG_IDX_W'($urandom_range(2, 255)), $urandom);
    put_reg(REG_MEASUREMENT_NOISE, r);
    cfg_if.valid <= 1'b0;
  endtask

  function automatic logic [DATA_W-1:0] pick_noise();
    case ($urandom_range(4))
      0: return '0;
      1: return NOISE_MAX;
      2: return DATA_W'($urandom_range(1, 65536));
      3: return DATA_W'($urandom_range(65536, 32'h0040_0000));
      default: return $urandom;
    endcase
  endfunction

  // Mostly a noisy drifting level, with full-range values and the extremes
  // mixed in so that every bit of the field toggles.
  function automatic logic signed [DATA_W-1:0] pick_measurement(logic [CH_W-1:0] ch);
    logic signed [DATA_W-1:0] jitter;
    case ($urandom_range(9))
      0, 1, 2: return $urandom;
      3: begin
        case ($urandom_range(4))
          0: return Z_MAX;
          1: return Z_MIN;
          2: return '0;
          3: return -1;
          default: return 1;
        endcase
      end
      default: begin
        jitter = DATA_W'($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000;
        level[ch] = level[ch] + jitter;
        jitter = DATA_W'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
        return level[ch] + jitter;
      end
    endcase
  endfunction

  initial begin
    logic [CH_W-1:0] ch;
    logic [DATA_W-1:0] q;
    logic [DATA_W-1:0] r;

    rst_n             <= 1'b0;
    in_if.valid       <= 1'b0;
    in_if.channel     <= '0;
    in_if.measurement <= '0;
    cfg_if.valid      <= 1'b0;
    cfg_if.index      <= '0;
    cfg_if.data       <= '0;
    foreach (level[i])
      level[i] = DATA_W'($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, on the noise values loaded at reset: extremes of the
    // measurement on every channel, starting from cleared slots.
    set_pace(PACE_FULL);
    send_measurement(2'd0, '0);
    send_measurement(2'd1, Z_MAX);
    send_measurement(2'd2, Z_MIN);
    send_measurement(2'd3, -1);
    send_measurement(2'd0, 1);
    send_measurement(2'd1, Z_MIN);
    send_measurement(2'd2, Z_MAX);
    send_measurement(2'd3, '0);
    wait_drained();

    // Both noise values zero: the first word on a slot gives a gain of one and
    // clears its covariance, so the second word hits the zero divisor.
    program_noise('0, '0);
    for (int i = 0; i < SKF_CHANNELS; i++) begin
      send_measurement(CH_W'(i), $urandom);
      send_measurement(CH_W'(i), (i % 2 == 0) ? Z_MAX : Z_MIN);
    end
    wait_drained();

    // Both noise values at their maximum: the prediction saturates once the
    // covariance has grown.
    program_noise(NOISE_MAX, NOISE_MAX);
    send_measurement(2'd0, Z_MAX);
    send_measurement(2'd0, Z_MIN);
    send_measurement(2'd0, Z_MAX);
    send_measurement(2'd1, Z_MIN);
    send_measurement(2'd1, -1);
    send_measurement(2'd1, Z_MAX);
    wait_drained();

    // Random part. Each phase loads new noise values while idle and uses its
    // own idling profile; the first phases pin the register extremes.
    ch = '0;
    for (int k = 0; k < RAND_PHASES; k++) begin
      case (k)
        0: begin
          q = PROCESS_NOISE_RESET;
          r = MEASUREMENT_NOISE_RESET;
        end
        1: begin
          q = '0;
          r = '0;
        end
        2: begin
          q = NOISE_MAX;
          r = NOISE_MAX;
        end
        3: begin
          q = NOISE_MAX;
          r = '0;
        end
        default: begin
          q = pick_noise();
          r = pick_noise();
        end
      endcase
      program_noise(q, r);
      set_pace(pace_t'(k % 4));
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        // Runs on one channel are common, so a slot converges over many words.
        if ($urandom_range(9) >= 3)
          ch = CH_W'($urandom_range(SKF_CHANNELS - 1));
        send_measurement(ch, pick_measurement(ch));
      end
      wait_drained();
    end

    set_pace(PACE_FULL);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("PASS scalar_kalman_filter");
    end else begin
      $display("FAIL scalar_kalman_filter");
    end
    $finish;
  end

  // Watchdog, several times the slowest correct run.
  initial begin
    #8_000_000;
    $display("FAIL scalar_kalman_filter");
    $finish;
  end

endmodule
